>>> src/gcbf_pkg.sv
// ============================================================================
// gcbf_pkg: ghost cell boundary fill shared definitions
// Widths, boundary kind codes, register indexes and stage payload types.
// ============================================================================
package gcbf_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned FieldW   = 2;
  localparam int unsigned RatioW   = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned FracW    = 16;
  localparam int unsigned MulW     = ValW + 1;
  localparam int unsigned ProdW    = MulW + RatioW + 1;
  localparam int unsigned LinW     = ValW + 3;
  localparam int unsigned SumW     = ValW + 6;

  localparam logic [RatioW-1:0]     RatioOne  = RatioW'(1) << FracW;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) << (FracW - 1);
  localparam logic signed [ValW-1:0]  ValMax    = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0]  ValMin    = {1'b1, {(ValW-1){1'b0}}};

  localparam logic [FieldW-1:0] FIELD_DENSITY = 2'd0;
  localparam logic              EDGE_OUTER    = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_ZERO_GRAD  = 3'd0,
    KIND_PARABOLIC  = 3'd1,
    KIND_FIXED_FLUX = 3'd2,
    KIND_ABSORB     = 3'd3,
    KIND_REFLECT    = 3'd4,
    KIND_LINEAR     = 3'd5,
    KIND_LOG_GRID   = 3'd6
  } bc_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INNER_BC      = 3'd0,
    REG_OUTER_BC      = 3'd1,
    REG_INNER_FLUX    = 3'd2,
    REG_INNER_SPACING = 3'd3,
    REG_OUTER_SPACING = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [KindW-1:0]  inner_bc_type;
    logic [KindW-1:0]  outer_bc_type;
    logic [RatioW-1:0] inner_flux_factor;
    logic [RatioW-1:0] inner_spacing_ratio;
    logic [RatioW-1:0] outer_spacing_ratio;
  } cfg_t;

  typedef struct packed {
    bc_kind_e                 kind;
    logic                     use_mul;
    logic signed [MulW-1:0]   mul_a;
    logic [RatioW-1:0]        factor;
    logic signed [ValW-1:0]   addend;
    logic signed [LinW-1:0]   g_lin;
  } stage1_t;

  typedef struct packed {
    bc_kind_e                 kind;
    logic                     use_mul;
    logic signed [ProdW-1:0]  prod;
    logic signed [ValW-1:0]   addend;
    logic signed [LinW-1:0]   g_lin;
  } stage2_t;

endpackage

>>> src/gcbf_if.sv
// ============================================================================
// gcbf_if: ghost cell boundary fill channel interfaces
// Item, result and configuration write channels with valid/ready.
// ============================================================================
interface gcbf_item_if;
  import gcbf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     edge_side;
  logic [FieldW-1:0]        field_kind;
  logic signed [ValW-1:0]   v_near;
  logic signed [ValW-1:0]   v_mid;
  logic signed [ValW-1:0]   v_far;

  modport source (output valid, edge_side, field_kind, v_near, v_mid, v_far, input ready);
  modport sink   (input valid, edge_side, field_kind, v_near, v_mid, v_far, output ready);
endinterface

interface gcbf_result_if;
  import gcbf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValW-1:0]   ghost_value;
  logic [KindW-1:0]         applied_kind;
  logic                     clipped;

  modport source (output valid, ghost_value, applied_kind, clipped, input ready);
  modport sink   (input valid, ghost_value, applied_kind, clipped, output ready);
endinterface

interface gcbf_cfg_if;
  import gcbf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CfgIdxW-1:0]    index;
  logic [CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/gcbf_cfg_regs.sv
// ============================================================================
// gcbf_cfg_regs: configuration register file
// Boundary kinds and Q4.16 ratios, written by index.
// ============================================================================
module gcbf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [gcbf_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [gcbf_pkg::CfgDataW-1:0] wr_data_i,
  output gcbf_pkg::cfg_t               cfg_o
);
  import gcbf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_INNER_BC:      cfg_d.inner_bc_type       = wr_data_i[KindW-1:0];
        REG_OUTER_BC:      cfg_d.outer_bc_type       = wr_data_i[KindW-1:0];
        REG_INNER_FLUX:    cfg_d.inner_flux_factor   = wr_data_i[RatioW-1:0];
        REG_INNER_SPACING: cfg_d.inner_spacing_ratio = wr_data_i[RatioW-1:0];
        REG_OUTER_SPACING: cfg_d.outer_spacing_ratio = wr_data_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_bc_type       <= KIND_ZERO_GRAD;
      cfg_q.outer_bc_type       <= KIND_ZERO_GRAD;
      cfg_q.inner_flux_factor   <= RatioOne;
      cfg_q.inner_spacing_ratio <= RatioOne;
      cfg_q.outer_spacing_ratio <= RatioOne;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/gcbf_decode.sv
// ============================================================================
// gcbf_decode: pipeline stage 1
// Correct the boundary kind, form direct results and multiplier operands.
// ============================================================================
module gcbf_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              edge_side_i,
  input  logic [gcbf_pkg::FieldW-1:0]       field_kind_i,
  input  logic signed [gcbf_pkg::ValW-1:0]  v_near_i,
  input  logic signed [gcbf_pkg::ValW-1:0]  v_mid_i,
  input  logic signed [gcbf_pkg::ValW-1:0]  v_far_i,
  input  gcbf_pkg::cfg_t                    cfg_i,
  output logic                              valid_o,
  output gcbf_pkg::stage1_t                 s1_o
);
  import gcbf_pkg::*;

  logic [KindW-1:0]        raw_kind;
  bc_kind_e                base_kind;
  bc_kind_e                kind;
  logic signed [LinW-1:0]  n_l, m_l, f_l;
  logic signed [MulW-1:0]  n_m, m_m;
  stage1_t                 s1_d, s1_q;
  logic                    valid_q;

  always_comb begin
    raw_kind = (edge_side_i == EDGE_OUTER) ? cfg_i.outer_bc_type : cfg_i.inner_bc_type;
    unique case (raw_kind)
      KIND_ZERO_GRAD:  base_kind = KIND_ZERO_GRAD;
      KIND_PARABOLIC:  base_kind = KIND_PARABOLIC;
      KIND_FIXED_FLUX: base_kind = KIND_FIXED_FLUX;
      KIND_ABSORB:     base_kind = KIND_ABSORB;
      KIND_REFLECT:    base_kind = KIND_REFLECT;
      KIND_LINEAR:     base_kind = KIND_LINEAR;
      KIND_LOG_GRID:   base_kind = KIND_LOG_GRID;
      default:         base_kind = KIND_ZERO_GRAD;
    endcase
    kind = base_kind;
    if (field_kind_i != FIELD_DENSITY) begin
      if (base_kind == KIND_ABSORB) begin
        kind = KIND_ZERO_GRAD;
      end else if (base_kind == KIND_FIXED_FLUX) begin
        kind = KIND_PARABOLIC;
      end
    end
  end

  assign n_l = LinW'(v_near_i);
  assign m_l = LinW'(v_mid_i);
  assign f_l = LinW'(v_far_i);
  assign n_m = MulW'(v_near_i);
  assign m_m = MulW'(v_mid_i);

  always_comb begin
    s1_d.kind    = kind;
    s1_d.use_mul = 1'b0;
    s1_d.mul_a   = '0;
    s1_d.factor  = '0;
    s1_d.addend  = v_near_i;
    s1_d.g_lin   = n_l;
    case (kind)
      KIND_PARABOLIC: s1_d.g_lin = n_l + (n_l <<< 1) - m_l - (m_l <<< 1) + f_l;
      KIND_FIXED_FLUX: begin
        if (edge_side_i != EDGE_OUTER) begin
          s1_d.use_mul = 1'b1;
          s1_d.mul_a   = n_m;
          s1_d.factor  = cfg_i.inner_flux_factor;
          s1_d.addend  = '0;
        end
      end
      KIND_ABSORB:  s1_d.g_lin = '0;
      KIND_REFLECT: s1_d.g_lin = m_l;
      KIND_LINEAR:  s1_d.g_lin = (n_l <<< 1) - m_l;
      KIND_LOG_GRID: begin
        s1_d.use_mul = 1'b1;
        s1_d.mul_a   = n_m - m_m;
        s1_d.factor  = (edge_side_i == EDGE_OUTER) ? cfg_i.outer_spacing_ratio
                                                   : cfg_i.inner_spacing_ratio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

>>> src/gcbf_mult.sv
// ============================================================================
// gcbf_mult: pipeline stage 2
// Multiply the operand by the unsigned Q4.16 ratio.
// ============================================================================
module gcbf_mult (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gcbf_pkg::stage1_t  s1_i,
  output logic               valid_o,
  output gcbf_pkg::stage2_t  s2_o
);
  import gcbf_pkg::*;

  logic signed [RatioW:0] factor_s;
  stage2_t                s2_d, s2_q;
  logic                   valid_q;

  assign factor_s = signed'({1'b0, s1_i.factor});

  always_comb begin
    s2_d.kind    = s1_i.kind;
    s2_d.use_mul = s1_i.use_mul;
    s2_d.prod    = ProdW'(s1_i.mul_a) * ProdW'(factor_s);
    s2_d.addend  = s1_i.addend;
    s2_d.g_lin   = s1_i.g_lin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

>>> src/gcbf_finish.sv
// ============================================================================
// gcbf_finish: pipeline stage 3 and output register
// Round the product, add, saturate to Q16.16 and flag clipping.
// ============================================================================
module gcbf_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  gcbf_pkg::stage2_t                 s2_i,
  output logic                              valid_o,
  output logic signed [gcbf_pkg::ValW-1:0]  ghost_value_o,
  output logic [gcbf_pkg::KindW-1:0]        applied_kind_o,
  output logic                              clipped_o
);
  import gcbf_pkg::*;

  logic signed [ProdW-1:0] rounded;
  logic signed [SumW-1:0]  mul_res;
  logic signed [SumW-1:0]  g_full;
  logic [SumW-ValW:0]      g_top;
  logic                    clip_d;
  logic signed [ValW-1:0]  value_d;
  logic                    valid_q;
  logic signed [ValW-1:0]  value_q;
  logic [KindW-1:0]        kind_q;
  logic                    clip_q;

  always_comb begin
    rounded = (s2_i.prod + RoundHalf) >>> FracW;
    mul_res = SumW'(rounded);
    g_full  = s2_i.use_mul ? (SumW'(s2_i.addend) + mul_res) : SumW'(s2_i.g_lin);
    g_top   = g_full[SumW-1:ValW-1];
    clip_d  = !((&g_top) || (~|g_top));
    if (clip_d) begin
      value_d = g_full[SumW-1] ? ValMin : ValMax;
    end else begin
      value_d = g_full[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      kind_q  <= s2_i.kind;
      clip_q  <= clip_d;
    end
  end

  assign valid_o        = valid_q;
  assign ghost_value_o  = value_q;
  assign applied_kind_o = kind_q;
  assign clipped_o      = clip_q;

endmodule

>>> src/ghost_cell_boundary_fill_core.sv
// ============================================================================
// ghost_cell_boundary_fill_core: ghost cell value for one 1D grid edge
// Corrects the boundary kind for the field and extrapolates in Q16.16.
//
//   channel   dir  handshake      payload
//   in_ch_i   in   valid/ready    edge_side, field_kind, v_near, v_mid, v_far
//   out_ch_o  out  valid/ready    ghost_value, applied_kind, clipped
//   cfg_i     in   valid/ready    index, data (always ready)
//
// One item per cycle while the output is not stalled; stages: decode, multiply, round/saturate.
// The multiply stage, 33 x 21 bits, sets the cycle time.
// Reset clears valid bits and loads the register defaults.
// A stalled output freezes all three stages together; ready follows it.
// ============================================================================
module ghost_cell_boundary_fill_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcbf_item_if.sink     in_ch_i,
  gcbf_result_if.source out_ch_o,
  gcbf_cfg_if.sink      cfg_i
);
  import gcbf_pkg::*;

  cfg_t     cfg;
  logic     en;
  logic     in_acc;
  logic     s1_valid, s2_valid;
  stage1_t  s1;
  stage2_t  s2;

  assign en             = !out_ch_o.valid || out_ch_o.ready;
  assign in_ch_i.ready  = en;
  assign in_acc         = in_ch_i.valid && en;
  assign cfg_i.ready    = 1'b1;

  gcbf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  gcbf_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_ch_i.valid),
    .edge_side_i  (in_ch_i.edge_side),
    .field_kind_i (in_ch_i.field_kind),
    .v_near_i     (in_ch_i.v_near),
    .v_mid_i      (in_ch_i.v_mid),
    .v_far_i      (in_ch_i.v_far),
    .cfg_i        (cfg),
    .valid_o      (s1_valid),
    .s1_o         (s1)
  );

  gcbf_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  gcbf_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s2_valid),
    .s2_i           (s2),
    .valid_o        (out_ch_o.valid),
    .ghost_value_o  (out_ch_o.ghost_value),
    .applied_kind_o (out_ch_o.applied_kind),
    .clipped_o      (out_ch_o.clipped)
  );

  a_clip_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && out_ch_o.clipped |->
      (out_ch_o.ghost_value == ValMax || out_ch_o.ghost_value == ValMin))
    else $error("clipped result not at a range limit");

  a_field_fix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_ch_i.field_kind != FIELD_DENSITY) |=>
      (s1.kind != KIND_FIXED_FLUX && s1.kind != KIND_ABSORB))
    else $error("density-only kind kept for non-density field");

  a_log_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && (s1.kind == KIND_LOG_GRID) |-> s1.use_mul)
    else $error("log-grid transaction bypassed the multiplier");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s2_valid |=> out_ch_o.valid)
    else $error("transaction lost between multiply and output");

endmodule

>>> tb/tb.sv
// ============================================================================
// tb: ghost cell boundary fill core testbench
// Drives edge items through the core under several register settings and
// random handshake stalls, predicts each ghost value, kind and saturation
// flag in Q16.16, and compares every result transaction in order.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcbf_pkg::*;

  localparam logic              EDGE_INNER     = 1'b0;
  localparam logic [FieldW-1:0] FIELD_PRESSURE = 2'd1;
  localparam logic [FieldW-1:0] FIELD_GRADIENT = 2'd2;
  localparam logic [FieldW-1:0] FIELD_SPARE    = 2'd3;
  localparam logic [KindW-1:0]  KIND_SPARE     = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_SPARE     = 3'd7;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic                   edge_side;
    logic [FieldW-1:0]      field_kind;
    logic signed [ValW-1:0] v_near;
    logic signed [ValW-1:0] v_mid;
    logic signed [ValW-1:0] v_far;
  } ghost_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] ghost_value;
    bc_kind_e               applied_kind;
    logic                   clipped;
  } ghost_result_t;

  logic clk = 1'b0;
  logic rst_ni;

  gcbf_item_if   item_ch ();
  gcbf_result_if res_ch ();
  gcbf_cfg_if    cfg_ch ();

  ghost_cell_boundary_fill_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_ch_i (item_ch),
    .out_ch_o(res_ch),
    .cfg_i   (cfg_ch)
  );

  cfg_t          bc_regs;
  ghost_result_t pending_ghosts [$];
  int unsigned   mismatch_count = 0;
  int unsigned   ghosts_checked = 0;
  int unsigned   clip_count     = 0;
  int unsigned   setting_count  = 0;
  bit            gaps_on  = 1'b1;
  bit            stall_on = 1'b1;
  bit            hold_req = 1'b0;

  always #5 clk = ~clk;

  function automatic longint round_scale(input longint value, input logic [RatioW-1:0] factor);
    return (value * longint'(factor) + longint'(RoundHalf)) >>> FracW;
  endfunction

  function automatic ghost_result_t fill_ghost(input ghost_item_t it);
    logic [KindW-1:0] raw;
    bc_kind_e         kind;
    longint           near_v, mid_v, far_v, g;
    ghost_result_t    r;
    raw = (it.edge_side == EDGE_OUTER) ? bc_regs.outer_bc_type : bc_regs.inner_bc_type;
    kind = (raw > KIND_LOG_GRID) ? KIND_ZERO_GRAD : bc_kind_e'(raw);
    if (it.field_kind != FIELD_DENSITY) begin
      if (kind == KIND_ABSORB) kind = KIND_ZERO_GRAD;
      else if (kind == KIND_FIXED_FLUX) kind = KIND_PARABOLIC;
    end
    near_v = longint'($signed(it.v_near));
    mid_v  = longint'($signed(it.v_mid));
    far_v  = longint'($signed(it.v_far));
    case (kind)
      KIND_PARABOLIC:  g = 3 * near_v - 3 * mid_v + far_v;
      KIND_FIXED_FLUX: begin
        g = (it.edge_side == EDGE_OUTER) ? near_v
                                          : round_scale(near_v, bc_regs.inner_flux_factor);
      end
      KIND_ABSORB:     g = 0;
      KIND_REFLECT:    g = mid_v;
      KIND_LINEAR:     g = 2 * near_v - mid_v;
      KIND_LOG_GRID: begin
        g = near_v + round_scale(near_v - mid_v, (it.edge_side == EDGE_OUTER)
                                 ? bc_regs.outer_spacing_ratio
                                 : bc_regs.inner_spacing_ratio);
      end
      default:         g = near_v;
    endcase
    r.clipped = 1'b0;
    if (g > longint'(ValMax)) begin
      g = longint'(ValMax);
      r.clipped = 1'b1;
    end else if (g < longint'(ValMin)) begin
      g = longint'(ValMin);
      r.clipped = 1'b1;
    end
    r.ghost_value  = g[ValW-1:0];
    r.applied_kind = kind;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    ghost_result_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_ghosts.size() == 0) begin
          report_mismatch("unexpected result", longint'(res_ch.ghost_value), 0);
        end else begin
          want = pending_ghosts.pop_front();
          ghosts_checked++;
          if (want.clipped) clip_count++;
          if (res_ch.ghost_value !== want.ghost_value) begin
            report_mismatch("ghost_value", longint'(res_ch.ghost_value),
                            longint'(want.ghost_value));
          end
          if (res_ch.applied_kind !== want.applied_kind) begin
            report_mismatch("applied_kind", longint'(res_ch.applied_kind),
                            longint'(want.applied_kind));
          end
          if (res_ch.clipped !== want.clipped) begin
            report_mismatch("clipped", longint'(res_ch.clipped), longint'(want.clipped));
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        pending_ghosts.push_back(fill_ghost('{item_ch.edge_side, item_ch.field_kind,
                                              item_ch.v_near, item_ch.v_mid,
                                              item_ch.v_far}));
      end
    end
  end

  initial begin : result_ready
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic ghost_item_t mk(input logic side, input logic [FieldW-1:0] field,
                                     input int near_v, input int mid_v, input int far_v);
    return '{side, field, near_v, mid_v, far_v};
  endfunction

  function automatic cfg_t bc_setting(input logic [KindW-1:0] inner_k,
                                      input logic [KindW-1:0] outer_k,
                                      input logic [RatioW-1:0] flux,
                                      input logic [RatioW-1:0] inner_sp,
                                      input logic [RatioW-1:0] outer_sp);
    return '{inner_k, outer_k, flux, inner_sp, outer_sp};
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0:       return ValMax;
      1:       return ValMin;
      2:       return int'($urandom_range(0, 4000)) - 2000;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic logic [RatioW-1:0] rand_ratio();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return RatioOne;
      3:       return RatioW'($urandom_range(0, 3 * 65536));
      default: return RatioW'($urandom);
    endcase
  endfunction

  function automatic cfg_t rand_setting();
    return bc_setting(KindW'($urandom_range(0, 7)), KindW'($urandom_range(0, 7)),
                      rand_ratio(), rand_ratio(), rand_ratio());
  endfunction

  function automatic ghost_item_t rand_item();
    return mk(1'($urandom_range(0, 1)), FieldW'($urandom_range(0, 3)),
              rand_value(), rand_value(), rand_value());
  endfunction

  task automatic send_item(input ghost_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.edge_side  <= it.edge_side;
    item_ch.field_kind <= it.field_kind;
    item_ch.v_near     <= it.v_near;
    item_ch.v_mid      <= it.v_mid;
    item_ch.v_far      <= it.v_far;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_ghosts.size() != 0) @(posedge clk);
  endtask

  task automatic load_registers(input cfg_t c, input bit touch_spare);
    logic [CfgIdxW-1:0]  idx [6];
    logic [CfgDataW-1:0] dat [6];
    int unsigned         n_writes;
    drain_results();
    idx[0] = REG_INNER_BC;
    idx[1] = REG_OUTER_BC;
    idx[2] = REG_INNER_FLUX;
    idx[3] = REG_INNER_SPACING;
    idx[4] = REG_OUTER_SPACING;
    idx[5] = REG_SPARE;
    dat[0] = {(CfgDataW - KindW)'($urandom), c.inner_bc_type};
    dat[1] = {(CfgDataW - KindW)'($urandom), c.outer_bc_type};
    dat[2] = c.inner_flux_factor;
    dat[3] = c.inner_spacing_ratio;
    dat[4] = c.outer_spacing_ratio;
    dat[5] = CfgDataW'($urandom);
    n_writes = touch_spare ? 6 : 5;
    for (int n = 0; n < n_writes; n++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[n];
      cfg_ch.data  <= dat[n];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx[n])
        REG_INNER_BC:      bc_regs.inner_bc_type       = dat[n][KindW-1:0];
        REG_OUTER_BC:      bc_regs.outer_bc_type       = dat[n][KindW-1:0];
        REG_INNER_FLUX:    bc_regs.inner_flux_factor   = dat[n][RatioW-1:0];
        REG_INNER_SPACING: bc_regs.inner_spacing_ratio = dat[n][RatioW-1:0];
        REG_OUTER_SPACING: bc_regs.outer_spacing_ratio = dat[n][RatioW-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    setting_count++;
  endtask

  task automatic test_defaults();
    send_item(mk(EDGE_INNER, FIELD_DENSITY, ValMax, ValMin, ValMax));
    send_item(mk(EDGE_OUTER, FIELD_SPARE, ValMin, ValMax, ValMin));
  endtask

  task automatic test_fixed_flux();
    load_registers(bc_setting(KIND_FIXED_FLUX, KIND_FIXED_FLUX, '1, RatioOne, RatioOne), 1'b0);
    send_item(mk(EDGE_INNER, FIELD_DENSITY, ValMax, 0, 0));
    send_item(mk(EDGE_INNER, FIELD_DENSITY, ValMin, 0, 0));
    send_item(mk(EDGE_INNER, FIELD_DENSITY, -3, 9, 1));
    send_item(mk(EDGE_OUTER, FIELD_DENSITY, ValMin, ValMax, ValMax));
    send_item(mk(EDGE_INNER, FIELD_PRESSURE, ValMax, ValMin, ValMax));
    send_item(mk(EDGE_INNER, FIELD_SPARE, ValMin, ValMax, ValMin));
  endtask

  task automatic test_absorb();
    load_registers(bc_setting(KIND_ABSORB, KIND_ABSORB, '0, RatioOne, RatioOne), 1'b0);
    send_item(mk(EDGE_INNER, FIELD_DENSITY, ValMax, 5, 6));
    send_item(mk(EDGE_OUTER, FIELD_GRADIENT, 1234, 5, 6));
    send_item(mk(EDGE_INNER, FIELD_SPARE, ValMin, 5, 6));
  endtask

  task automatic test_reflect_linear();
    load_registers(bc_setting(KIND_REFLECT, KIND_LINEAR, RatioOne, RatioOne, RatioOne), 1'b0);
    send_item(mk(EDGE_INNER, FIELD_DENSITY, 5, ValMin, 7));
    send_item(mk(EDGE_OUTER, FIELD_PRESSURE, ValMax, ValMin, 0));
    send_item(mk(EDGE_OUTER, FIELD_DENSITY, ValMin, ValMax, 0));
    send_item(mk(EDGE_OUTER, FIELD_GRADIENT, 100, 40, 0));
  endtask

  task automatic test_log_grid();
    load_registers(bc_setting(KIND_LOG_GRID, KIND_LOG_GRID, RatioOne, RatioW'(32768), '1),
                   1'b0);
    send_item(mk(EDGE_INNER, FIELD_DENSITY, 1, 0, 0));
    send_item(mk(EDGE_INNER, FIELD_DENSITY, 0, 1, 0));
    send_item(mk(EDGE_OUTER, FIELD_DENSITY, ValMax, ValMin, 0));
    send_item(mk(EDGE_OUTER, FIELD_PRESSURE, ValMin, ValMax, 0));
  endtask

  task automatic test_spare_codes();
    load_registers(bc_setting(KIND_SPARE, KIND_PARABOLIC, RatioOne, '0, RatioOne), 1'b1);
    send_item(mk(EDGE_INNER, FIELD_DENSITY, 123, 4, 5));
    send_item(mk(EDGE_OUTER, FIELD_DENSITY, 10, 20, 30));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      load_registers(rand_setting(), phase == 3);
      repeat (45) send_item(rand_item());
    end
  endtask

  task automatic test_backpressure();
    load_registers(rand_setting(), 1'b0);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_item(rand_item());
    gaps_on  = 1'b1;
  endtask

  task automatic test_steady_stream();
    stall_on = 1'b0;
    gaps_on  = 1'b0;
    load_registers(rand_setting(), 1'b0);
    repeat (40) send_item(rand_item());
  endtask

  initial begin
    bc_regs = bc_setting(KIND_ZERO_GRAD, KIND_ZERO_GRAD, RatioOne, RatioOne, RatioOne);
    rst_ni             <= 1'b0;
    item_ch.valid      <= 1'b0;
    item_ch.edge_side  <= 1'b0;
    item_ch.field_kind <= '0;
    item_ch.v_near     <= '0;
    item_ch.v_mid      <= '0;
    item_ch.v_far      <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    test_defaults();
    test_fixed_flux();
    test_absorb();
    test_reflect_linear();
    test_log_grid();
    test_spare_codes();
    test_random();
    test_backpressure();
    test_steady_stream();
    drain_results();
    repeat (DrainCycles) @(posedge clk);
    $display("checked %0d ghost values over %0d register settings, %0d of them saturated",
             ghosts_checked, setting_count, clip_count);
    $display("all kinds on both edges, every field kind, long output hold included");
    if (mismatch_count == 0) begin
      $display("[ghost_cell_boundary_fill_core] OK");
    end else begin
      $display("[ghost_cell_boundary_fill_core] ERROR");
    end
    $finish;
  end

  initial begin : run_limit
    #2ms;
    $display("[ghost_cell_boundary_fill_core] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/gcbf_pkg.sv
src/gcbf_if.sv
src/gcbf_cfg_regs.sv
src/gcbf_decode.sv
src/gcbf_mult.sv
src/gcbf_finish.sv
src/ghost_cell_boundary_fill_core.sv
tb/tb.sv
